### src/ghtp_pkg.sv
// ----------------------------------------------------------------------------
// ghtp_pkg
// Shared types, constants and lookup functions of the grid heading turn
// planner: ratio-to-direction table, arctangent table, reciprocal constants.
// ----------------------------------------------------------------------------
`default_nettype none

package ghtp_pkg;

   localparam int CoefW    = 10;   // sine and cosine in thousandths
   localparam int AtanIdxW = 5;    // arctangent table index, entries 0 to 14 nonzero
   localparam int AtanW    = 14;
   localparam int CordW    = 27;   // cordic x and y, input scaled by 256
   localparam int AngW     = 18;   // binary angle accumulator
   localparam int VecW     = 18;   // vector components before scaling
   localparam int MulW     = 32;

   // floor(p / 1000) for p < 2^18 as (p * GoalRecip) >> GoalShift
   localparam logic [MulW-1:0] GoalRecip  = 32'd268436;
   localparam int              GoalShift  = 28;
   // arc = floor(mag * 3707079327 / (2^22 * 78125))
   localparam logic [MulW-1:0] ArcMul     = 32'd3707079327;
   localparam int              ArcShift   = 22;
   // floor(v / 78125) for v < 2^25
   localparam logic [MulW-1:0] ArcRecip   = 32'd56294996;
   localparam int              ArcRecShft = 42;
   // ticks = floor(arc * 75 / 118)
   localparam logic [MulW-1:0] TickMul    = 32'd75;
   localparam logic [MulW-1:0] TickRecip  = 32'd35545;
   localparam int              TickShift  = 22;

   localparam logic signed [AngW-1:0] QuarterTurn = 18'sd16384;

   localparam logic [7:0] MaxAccelReset = 8'd10;
   localparam logic       CsrMaxAccel   = 1'b0;   // register index

   typedef struct packed {
      logic [CoefW-1:0] sine;
      logic [CoefW-1:0] cosine;
   } coef_type;

   // direction coefficients picked from row and column distance
   function automatic coef_type ratio_coef(input logic [1:0] ar, input logic [1:0] ac);
      coef_type c;
      c.sine   = 10'd0;
      c.cosine = 10'd1000;
      if (ac == 2'd0) begin
         c.sine   = 10'd1000;
         c.cosine = 10'd0;
      end else if (ar == 2'd0) begin
         c.sine   = 10'd0;
         c.cosine = 10'd1000;
      end else if (ar == ac) begin
         c.sine   = 10'd707;
         c.cosine = 10'd707;
      end else begin
         unique case ({ar, ac})
            4'b01_11: begin c.sine = 10'd316; c.cosine = 10'd949; end
            4'b01_10: begin c.sine = 10'd447; c.cosine = 10'd894; end
            4'b10_11: begin c.sine = 10'd555; c.cosine = 10'd832; end
            4'b11_10: begin c.sine = 10'd832; c.cosine = 10'd555; end
            4'b10_01: begin c.sine = 10'd894; c.cosine = 10'd447; end
            4'b11_01: begin c.sine = 10'd949; c.cosine = 10'd316; end
            default:  begin c.sine = 10'd0;   c.cosine = 10'd1000; end
         endcase
      end
      return c;
   endfunction

   // atan(2^-i) in binary angle units, 65536 per turn
   function automatic logic [AtanW-1:0] atan_bam(input logic [AtanIdxW-1:0] idx);
      logic [AtanW-1:0] v;
      unique case (idx)
         5'd0:    v = 14'd8192;
         5'd1:    v = 14'd4836;
         5'd2:    v = 14'd2555;
         5'd3:    v = 14'd1297;
         5'd4:    v = 14'd651;
         5'd5:    v = 14'd326;
         5'd6:    v = 14'd163;
         5'd7:    v = 14'd81;
         5'd8:    v = 14'd41;
         5'd9:    v = 14'd20;
         5'd10:   v = 14'd10;
         5'd11:   v = 14'd5;
         5'd12:   v = 14'd3;
         5'd13:   v = 14'd1;
         5'd14:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

### src/ghtp_req_if.sv
// ----------------------------------------------------------------------------
// ghtp_req_if
// Request channel of the turn planner: valid/ready handshake and command.
// ----------------------------------------------------------------------------
`default_nettype none

interface ghtp_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   logic [7:0]        target_region;
   logic [7:0]        current_region;
   logic signed [15:0] heading_x;
   logic signed [15:0] heading_y;

   modport source (
      output valid, func, target_region, current_region, heading_x, heading_y,
      input  ready
   );
   modport sink (
      input  valid, func, target_region, current_region, heading_x, heading_y,
      output ready
   );
endinterface

`default_nettype wire

### src/ghtp_rsp_if.sv
// ----------------------------------------------------------------------------
// ghtp_rsp_if
// Response channel of the turn planner: valid/ready handshake and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface ghtp_rsp_if;
   logic              valid;
   logic              ready;
   logic [7:0]        turn_ticks;
   logic              turn_ccw;
   logic signed [8:0] goal_x;
   logic signed [8:0] goal_y;
   logic              on_path;
   logic              regions_valid;

   modport source (
      output valid, turn_ticks, turn_ccw, goal_x, goal_y, on_path, regions_valid,
      input  ready
   );
   modport sink (
      input  valid, turn_ticks, turn_ccw, goal_x, goal_y, on_path, regions_valid,
      output ready
   );
endinterface

`default_nettype wire

### src/grid_heading_turn_planner_top.sv
// ----------------------------------------------------------------------------
// grid_heading_turn_planner_top
// Plans the turn toward a target cell of a 4x4 grid and checks cells against
// the held path. One sequencer drives a shared cordic stage and one multiplier.
// ----------------------------------------------------------------------------
// sequence: a plan with valid cells runs goal x and y multiply and divide, goal
//   write, cordic of goal then heading angle, arc and tick multiply and divide,
//   finish, then rsp valid; an invalid cell skips the goal steps and a zero
//   vector its cordic steps; a check gives rsp valid in the cycle after accept
// flow: one transaction in flight; a new request waits until the last rsp is taken
// reset: synchronous, max_accel back to 10, held goal and path cleared
`default_nettype none

module grid_heading_turn_planner_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   ghtp_req_if.sink         req_ch,
   ghtp_rsp_if.source       rsp_ch,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int StepW    = $clog2(CORDIC_STEPS);
   localparam int CordW    = ghtp_pkg::CordW;
   localparam int AngW     = ghtp_pkg::AngW;
   localparam int VecW     = ghtp_pkg::VecW;
   localparam int MulW     = ghtp_pkg::MulW;
   localparam int AtanIdxW = ghtp_pkg::AtanIdxW;
   localparam int DiffW    = AngW + 1;
   localparam int GoalSh   = ghtp_pkg::GoalShift;
   localparam int ArcSh    = ghtp_pkg::ArcShift;
   localparam int ArcRecSh = ghtp_pkg::ArcRecShft;
   localparam int TickSh   = ghtp_pkg::TickShift;

   localparam logic signed [DiffW-1:0] HalfTurnPos = 19'sd32768;
   localparam logic signed [DiffW-1:0] HalfTurnNeg = -19'sd32768;
   localparam logic signed [DiffW-1:0] FullTurn    = 19'sd65536;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_GX_MUL   = 4'd1;
   localparam logic [3:0] S_GX_DIV   = 4'd2;
   localparam logic [3:0] S_GY_MUL   = 4'd3;
   localparam logic [3:0] S_GY_DIV   = 4'd4;
   localparam logic [3:0] S_GOAL_WR  = 4'd5;
   localparam logic [3:0] S_ANG_INIT = 4'd6;
   localparam logic [3:0] S_ANG_STEP = 4'd7;
   localparam logic [3:0] S_ANG_NEXT = 4'd8;
   localparam logic [3:0] S_ARC_MUL  = 4'd9;
   localparam logic [3:0] S_ARC_DIV  = 4'd10;
   localparam logic [3:0] S_TCK_MUL  = 4'd11;
   localparam logic [3:0] S_TCK_DIV  = 4'd12;
   localparam logic [3:0] S_FINISH   = 4'd13;
   localparam logic [3:0] S_OUT      = 4'd14;

   logic [3:0]               state_ff, state_in;
   logic [7:0]               max_accel_ff, max_accel_in;
   logic signed [8:0]        held_goal_x_ff, held_goal_x_in;
   logic signed [8:0]        held_goal_y_ff, held_goal_y_in;
   logic [1:0]               path_target_row_ff, path_target_row_in;
   logic [1:0]               path_target_col_ff, path_target_col_in;
   logic signed [2:0]        path_row_delta_ff, path_row_delta_in;
   logic signed [2:0]        path_col_delta_ff, path_col_delta_in;

   logic signed [15:0]       hx_ff, hx_in;
   logic signed [15:0]       hy_ff, hy_in;
   ghtp_pkg::coef_type       coef_ff, coef_in;
   logic                     sel_ff, sel_in;       // 0 goal angle, 1 heading angle
   logic [StepW-1:0]         step_ff, step_in;
   logic signed [CordW-1:0]  cx_ff, cx_in;
   logic signed [CordW-1:0]  cy_ff, cy_in;
   logic signed [AngW-1:0]   z_ff, z_in;
   logic signed [AngW-1:0]   zg_ff, zg_in;
   logic [15:0]              mag_ff, mag_in;
   logic                     dneg_ff, dneg_in;
   logic [2*MulW-1:0]        prod_ff, prod_in;

   logic [7:0]               ticks_ff, ticks_in;
   logic                     ccw_ff, ccw_in;
   logic                     on_path_ff, on_path_in;
   logic                     valid_ff, valid_in;

   logic [MulW-1:0]          mul_a, mul_b;

   // request decode
   logic                     creg_ok, plan_ok;
   logic [1:0]               t_row, t_col, c_row, c_col;
   logic signed [2:0]        d_row, d_col;
   logic [1:0]               a_row, a_col;
   logic                     col_ok, row_ok;

   // cordic datapath
   logic signed [VecW-1:0]   src_x, src_y, px, py;
   logic signed [CordW-1:0]  sh_x, sh_y;
   logic signed [AngW-1:0]   atan_s;

   // angle difference
   logic signed [DiffW-1:0]  ang_diff, ang_wrap, ang_abs;
   logic [8:0]               goal_mag;

   assign creg_ok = (req_ch.current_region[7:4] == 4'd0);
   assign plan_ok = creg_ok && (req_ch.target_region[7:4] == 4'd0);
   assign t_row   = req_ch.target_region[3:2];
   assign t_col   = req_ch.target_region[1:0];
   assign c_row   = req_ch.current_region[3:2];
   assign c_col   = req_ch.current_region[1:0];
   assign d_row   = $signed({1'b0, t_row}) - $signed({1'b0, c_row});
   assign d_col   = $signed({1'b0, t_col}) - $signed({1'b0, c_col});
   assign a_row   = d_row[2] ? 2'(-d_row) : d_row[1:0];
   assign a_col   = d_col[2] ? 2'(-d_col) : d_col[1:0];

   // path check against the held target and direction
   always_comb begin
      priority if (path_col_delta_ff < 0) begin
         col_ok = (c_col > path_target_col_ff);
      end else if (path_col_delta_ff > 0) begin
         col_ok = (c_col < path_target_col_ff);
      end else begin
         col_ok = (c_col == path_target_col_ff);
      end
      priority if (path_row_delta_ff < 0) begin
         row_ok = (c_row > path_target_row_ff);
      end else if (path_row_delta_ff > 0) begin
         row_ok = (c_row < path_target_row_ff);
      end else begin
         row_ok = (c_row == path_target_row_ff);
      end
   end

   assign src_x  = sel_ff ? VecW'(hx_ff) : VecW'(held_goal_x_ff);
   assign src_y  = sel_ff ? VecW'(hy_ff) : VecW'(held_goal_y_ff);
   assign px     = -src_x;
   assign py     = src_y;
   assign sh_x   = cx_ff >>> step_ff;
   assign sh_y   = cy_ff >>> step_ff;
   assign atan_s = AngW'(ghtp_pkg::atan_bam(AtanIdxW'(step_ff)));

   assign ang_diff = DiffW'(zg_ff) - DiffW'(z_ff);
   always_comb begin
      priority if (ang_diff > HalfTurnPos) begin
         ang_wrap = ang_diff - FullTurn;
      end else if (ang_diff < HalfTurnNeg) begin
         ang_wrap = ang_diff + FullTurn;
      end else begin
         ang_wrap = ang_diff;
      end
   end
   assign ang_abs  = ang_wrap[DiffW-1] ? -ang_wrap : ang_wrap;
   assign goal_mag = {1'b0, prod_ff[GoalSh +: 8]};

   assign prod_in = mul_a * mul_b;

   always_comb begin
      state_in           = state_ff;
      max_accel_in       = max_accel_ff;
      held_goal_x_in     = held_goal_x_ff;
      held_goal_y_in     = held_goal_y_ff;
      path_target_row_in = path_target_row_ff;
      path_target_col_in = path_target_col_ff;
      path_row_delta_in  = path_row_delta_ff;
      path_col_delta_in  = path_col_delta_ff;
      hx_in              = hx_ff;
      hy_in              = hy_ff;
      coef_in            = coef_ff;
      sel_in             = sel_ff;
      step_in            = step_ff;
      cx_in              = cx_ff;
      cy_in              = cy_ff;
      z_in               = z_ff;
      zg_in              = zg_ff;
      mag_in             = mag_ff;
      dneg_in            = dneg_ff;
      ticks_in           = ticks_ff;
      ccw_in             = ccw_ff;
      on_path_in         = on_path_ff;
      valid_in           = valid_ff;
      mul_a              = '0;
      mul_b              = '0;

      if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
          (csr_paddr[2] == ghtp_pkg::CsrMaxAccel)) begin
         max_accel_in = csr_pwdata[7:0];
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               hx_in = req_ch.heading_x;
               hy_in = req_ch.heading_y;
               if (req_ch.func) begin
                  ticks_in   = 8'd0;
                  ccw_in     = 1'b0;
                  valid_in   = creg_ok;
                  on_path_in = creg_ok && col_ok && row_ok;
                  state_in   = S_OUT;
               end else begin
                  valid_in   = plan_ok;
                  on_path_in = 1'b0;
                  sel_in     = 1'b0;
                  if (plan_ok) begin
                     path_target_row_in = t_row;
                     path_target_col_in = t_col;
                     path_row_delta_in  = d_row;
                     path_col_delta_in  = d_col;
                     coef_in            = ghtp_pkg::ratio_coef(a_row, a_col);
                     state_in           = S_GX_MUL;
                  end else begin
                     state_in = S_ANG_INIT;
                  end
               end
            end
         end
         S_GX_MUL: begin
            mul_a    = MulW'(max_accel_ff);
            mul_b    = MulW'(coef_ff.cosine);
            state_in = S_GX_DIV;
         end
         S_GX_DIV: begin
            mul_a    = MulW'(prod_ff[17:0]);
            mul_b    = ghtp_pkg::GoalRecip;
            state_in = S_GY_MUL;
         end
         S_GY_MUL: begin
            held_goal_x_in = path_col_delta_ff[2] ? $signed(goal_mag) : $signed(-goal_mag);
            mul_a          = MulW'(max_accel_ff);
            mul_b          = MulW'(coef_ff.sine);
            state_in       = S_GY_DIV;
         end
         S_GY_DIV: begin
            mul_a    = MulW'(prod_ff[17:0]);
            mul_b    = ghtp_pkg::GoalRecip;
            state_in = S_GOAL_WR;
         end
         S_GOAL_WR: begin
            held_goal_y_in = path_row_delta_ff[2] ? $signed(goal_mag) : $signed(-goal_mag);
            state_in       = S_ANG_INIT;
         end
         S_ANG_INIT: begin
            step_in = '0;
            if ((px == 0) && (py == 0)) begin
               z_in     = '0;
               state_in = S_ANG_NEXT;
            end else begin
               // vectors in the left half plane get a quarter turn first
               priority if (px < 0 && py >= 0) begin
                  cx_in = CordW'(py) <<< 8;
                  cy_in = CordW'(-px) <<< 8;
                  z_in  = ghtp_pkg::QuarterTurn;
               end else if (px < 0) begin
                  cx_in = CordW'(-py) <<< 8;
                  cy_in = CordW'(px) <<< 8;
                  z_in  = -ghtp_pkg::QuarterTurn;
               end else begin
                  cx_in = CordW'(px) <<< 8;
                  cy_in = CordW'(py) <<< 8;
                  z_in  = '0;
               end
               state_in = S_ANG_STEP;
            end
         end
         S_ANG_STEP: begin
            if (!cy_ff[CordW-1]) begin
               cx_in = cx_ff + sh_y;
               cy_in = cy_ff - sh_x;
               z_in  = z_ff + atan_s;
            end else begin
               cx_in = cx_ff - sh_y;
               cy_in = cy_ff + sh_x;
               z_in  = z_ff - atan_s;
            end
            step_in = step_ff + 1'b1;
            if (step_ff == StepW'(CORDIC_STEPS - 1)) begin
               state_in = S_ANG_NEXT;
            end
         end
         S_ANG_NEXT: begin
            if (!sel_ff) begin
               zg_in    = z_ff;
               sel_in   = 1'b1;
               state_in = S_ANG_INIT;
            end else begin
               mag_in   = ang_abs[15:0];
               dneg_in  = ang_wrap[DiffW-1];
               state_in = S_ARC_MUL;
            end
         end
         S_ARC_MUL: begin
            mul_a    = MulW'(mag_ff);
            mul_b    = ghtp_pkg::ArcMul;
            state_in = S_ARC_DIV;
         end
         S_ARC_DIV: begin
            mul_a    = MulW'(prod_ff[ArcSh +: 25]);
            mul_b    = ghtp_pkg::ArcRecip;
            state_in = S_TCK_MUL;
         end
         S_TCK_MUL: begin
            mul_a    = MulW'(prod_ff[ArcRecSh +: 9]);
            mul_b    = ghtp_pkg::TickMul;
            state_in = S_TCK_DIV;
         end
         S_TCK_DIV: begin
            mul_a    = MulW'(prod_ff[14:0]);
            mul_b    = ghtp_pkg::TickRecip;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            ticks_in = prod_ff[TickSh +: 8];
            // zero ticks count as counter-clockwise
            ccw_in   = !dneg_ff || (prod_ff[TickSh +: 8] == 8'd0);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ch.ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= S_IDLE;
         max_accel_ff       <= ghtp_pkg::MaxAccelReset;
         held_goal_x_ff     <= '0;
         held_goal_y_ff     <= '0;
         path_target_row_ff <= '0;
         path_target_col_ff <= '0;
         path_row_delta_ff  <= '0;
         path_col_delta_ff  <= '0;
      end else begin
         state_ff           <= state_in;
         max_accel_ff       <= max_accel_in;
         held_goal_x_ff     <= held_goal_x_in;
         held_goal_y_ff     <= held_goal_y_in;
         path_target_row_ff <= path_target_row_in;
         path_target_col_ff <= path_target_col_in;
         path_row_delta_ff  <= path_row_delta_in;
         path_col_delta_ff  <= path_col_delta_in;
      end
   end

   always_ff @(posedge clock) begin
      hx_ff      <= hx_in;
      hy_ff      <= hy_in;
      coef_ff    <= coef_in;
      sel_ff     <= sel_in;
      step_ff    <= step_in;
      cx_ff      <= cx_in;
      cy_ff      <= cy_in;
      z_ff       <= z_in;
      zg_ff      <= zg_in;
      mag_ff     <= mag_in;
      dneg_ff    <= dneg_in;
      prod_ff    <= prod_in;
      ticks_ff   <= ticks_in;
      ccw_ff     <= ccw_in;
      on_path_ff <= on_path_in;
      valid_ff   <= valid_in;
   end

   assign req_ch.ready = (state_ff == S_IDLE);

   assign rsp_ch.valid         = (state_ff == S_OUT);
   assign rsp_ch.turn_ticks    = ticks_ff;
   assign rsp_ch.turn_ccw      = ccw_ff;
   assign rsp_ch.goal_x        = held_goal_x_ff;
   assign rsp_ch.goal_y        = held_goal_y_ff;
   assign rsp_ch.on_path       = on_path_ff;
   assign rsp_ch.regions_valid = valid_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == ghtp_pkg::CsrMaxAccel) ? {24'd0, max_accel_ff} : 32'd0;

endmodule

`default_nettype wire

### tb/sv/ghtp_tb_pkg.sv
// ----------------------------------------------------------------------------
// ghtp_tb_pkg
// Command codes and the grid cell count shared by the turn planner stimulus and its checker.
// ----------------------------------------------------------------------------

package ghtp_tb_pkg;

   typedef enum logic {
      FuncPlan  = 1'b0,
      FuncCheck = 1'b1
   } func_code_type;

   localparam int CellCount = 16;   // cells of the 4x4 grid

endpackage

### tb/sv/ghtp_turn_check.sv
// ----------------------------------------------------------------------------
// ghtp_turn_check
// Watches the request, response and register ports of the turn planner,
// predicts every response from its own copy of the goal and path state and
// compares the responses in order, field by field.
// ----------------------------------------------------------------------------

module ghtp_turn_check #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ghtp_req_if         req_mon,
   ghtp_rsp_if         rsp_mon,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] MaxAccelAddr = 3'(4 * ghtp_pkg::CsrMaxAccel);
   localparam int QuarterBam = 16384;
   localparam int HalfBam    = 32768;
   localparam int FullBam    = 65536;

   typedef struct packed {
      ghtp_tb_pkg::func_code_type func;
      logic [7:0]                 target;
      logic [7:0]                 current;
      logic signed [15:0]         heading_x;
      logic signed [15:0]         heading_y;
   } planner_cmd_type;

   typedef struct packed {
      logic [7:0]        turn_ticks;
      logic              turn_ccw;
      logic signed [8:0] goal_x;
      logic signed [8:0] goal_y;
      logic              on_path;
      logic              regions_valid;
   } turn_result_type;

   int atan_units [0:23] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
                             3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};
   int ratio_key    [0:7] = '{0, 333, 500, 666, 1000, 1500, 2000, 3000};
   int sine_milli   [0:7] = '{0, 316, 447, 555, 707, 832, 894, 949};
   int cosine_milli [0:7] = '{1000, 949, 894, 832, 707, 555, 447, 316};

   int max_accel = 10;
   int held_goal_x, held_goal_y;
   int path_row, path_col, path_row_delta, path_col_delta;

   turn_result_type expected_turns[$];
   int mismatches = 0;
   int queued_n = 0;

   assign fail_count  = mismatches;
   assign outstanding = queued_n;

   // atan2(y, -x) in binary angle units by vectoring cordic
   function automatic int bearing_bam(input int x, input int y);
      int px, py, cx, cy, nx, ny, z, i;
      px = -x;
      py = y;
      z = 0;
      if (px == 0 && py == 0) return 0;
      if (px < 0) begin
         if (py >= 0) begin
            cx = py;
            cy = -px;
            z = QuarterBam;
         end else begin
            cx = -py;
            cy = px;
            z = -QuarterBam;
         end
      end else begin
         cx = px;
         cy = py;
      end
      cx = cx * 256;
      cy = cy * 256;
      for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         if (cy >= 0) begin
            nx = cx + (cy >>> i);
            ny = cy - (cx >>> i);
            z += atan_units[i];
         end else begin
            nx = cx - (cy >>> i);
            ny = cy + (cx >>> i);
            z -= atan_units[i];
         end
         cx = nx;
         cy = ny;
      end
      return z;
   endfunction

   function automatic turn_result_type plan_turn(input planner_cmd_type cmd);
      turn_result_type r;
      int tr, tc, cr, cc, dr, dc, ar, ac, ratio, sine, cosine, mx, my, d, k;
      bit col_ok, row_ok;
      longint unsigned mag, arc, ticks;
      r = '0;
      if (cmd.func == ghtp_tb_pkg::FuncPlan) begin
         r.regions_valid = (cmd.target < ghtp_tb_pkg::CellCount) &&
                           (cmd.current < ghtp_tb_pkg::CellCount);
         if (r.regions_valid) begin
            tr = cmd.target[3:2];
            tc = cmd.target[1:0];
            cr = cmd.current[3:2];
            cc = cmd.current[1:0];
            dr = tr - cr;
            dc = tc - cc;
            path_row = tr;
            path_col = tc;
            path_row_delta = dr;
            path_col_delta = dc;
            if (dc == 0) begin
               sine = 1000;
               cosine = 0;
            end else begin
               sine = 0;
               cosine = 1000;
               ar = (dr < 0) ? -dr : dr;
               ac = (dc < 0) ? -dc : dc;
               ratio = (1000 * ar) / ac;
               for (k = 0; k < 8; k++) begin
                  if (ratio_key[k] == ratio) begin
                     sine = sine_milli[k];
                     cosine = cosine_milli[k];
                  end
               end
            end
            mx = (max_accel * cosine) / 1000;
            my = (max_accel * sine) / 1000;
            held_goal_x = (dc < 0) ? mx : -mx;
            held_goal_y = (dr < 0) ? my : -my;
         end
         d = bearing_bam(held_goal_x, held_goal_y) - bearing_bam(cmd.heading_x, cmd.heading_y);
         if (d > HalfBam) d -= FullBam;
         if (d < -HalfBam) d += FullBam;
         if (d > HalfBam) d = HalfBam;
         if (d < -HalfBam) d = -HalfBam;
         mag = (d < 0) ? -d : d;
         arc = (mag * 64'd236 * 64'd314159265) / 64'd6553600000000;
         ticks = (arc * 64'd150) / 64'd236;
         r.turn_ticks = 8'(ticks);
         r.turn_ccw = (d >= 0) || (ticks == 0);
      end else begin
         r.regions_valid = cmd.current < ghtp_tb_pkg::CellCount;
         if (r.regions_valid) begin
            cr = cmd.current[3:2];
            cc = cmd.current[1:0];
            col_ok = 1'b1;
            row_ok = 1'b1;
            if (path_col_delta < 0 && cc <= path_col) col_ok = 1'b0;
            else if (path_col_delta > 0 && cc >= path_col) col_ok = 1'b0;
            else if (path_col_delta == 0 && cc != path_col) col_ok = 1'b0;
            if (path_row_delta < 0 && cr <= path_row) row_ok = 1'b0;
            else if (path_row_delta > 0 && cr >= path_row) row_ok = 1'b0;
            else if (path_row_delta == 0 && cr != path_row) row_ok = 1'b0;
            r.on_path = col_ok && row_ok;
         end
      end
      r.goal_x = held_goal_x[8:0];
      r.goal_y = held_goal_y[8:0];
      return r;
   endfunction

   task automatic mismatch(input string field, input int want, input int got);
      $error("%s expected %0d got %0d", field, want, got);
      mismatches++;
   endtask

   always @(posedge clock) begin : watch
      planner_cmd_type cmd;
      turn_result_type want, got;
      if (reset) begin
         max_accel = 10;
         held_goal_x = 0;
         held_goal_y = 0;
         path_row = 0;
         path_col = 0;
         path_row_delta = 0;
         path_col_delta = 0;
         expected_turns.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MaxAccelAddr)
            max_accel = csr_pwdata[7:0];
         if (req_mon.valid && req_mon.ready) begin
            cmd.func      = ghtp_tb_pkg::func_code_type'(req_mon.func);
            cmd.target    = req_mon.target_region;
            cmd.current   = req_mon.current_region;
            cmd.heading_x = req_mon.heading_x;
            cmd.heading_y = req_mon.heading_y;
            expected_turns.push_back(plan_turn(cmd));
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.turn_ticks    = rsp_mon.turn_ticks;
            got.turn_ccw      = rsp_mon.turn_ccw;
            got.goal_x        = rsp_mon.goal_x;
            got.goal_y        = rsp_mon.goal_y;
            got.on_path       = rsp_mon.on_path;
            got.regions_valid = rsp_mon.regions_valid;
            if (expected_turns.size() == 0) begin
               $error("rsp transaction with nothing expected");
               mismatches++;
            end else begin
               want = expected_turns.pop_front();
               if (got.turn_ticks !== want.turn_ticks)
                  mismatch("turn_ticks", want.turn_ticks, got.turn_ticks);
               if (got.turn_ccw !== want.turn_ccw)
                  mismatch("turn_ccw", want.turn_ccw, got.turn_ccw);
               if (got.goal_x !== want.goal_x)
                  mismatch("goal_x", want.goal_x, got.goal_x);
               if (got.goal_y !== want.goal_y)
                  mismatch("goal_y", want.goal_y, got.goal_y);
               if (got.on_path !== want.on_path)
                  mismatch("on_path", want.on_path, got.on_path);
               if (got.regions_valid !== want.regions_valid)
                  mismatch("regions_valid", want.regions_valid, got.regions_valid);
            end
         end
      end
      queued_n <= expected_turns.size();
   end

endmodule

### tb/sv/grid_heading_turn_planner_top_test.sv
// ----------------------------------------------------------------------------
// grid_heading_turn_planner_top_test
// Drives plan and check commands into the turn planner under several goal
// magnitudes, with bursty requests and a stalling response side; the checker
// beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module grid_heading_turn_planner_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Steps     = 16;
   localparam int LongHold  = 400;
   localparam int DrainWait = 60;   // idle wait after the last drain before the verdict

   typedef enum {ReadyAlways, ReadyCoin, ReadySparse, ReadyPattern} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count, outstanding;
   int burst_left = 0;
   int hold_requests = 0;
   int holds_served = 0;

   ghtp_req_if req();
   ghtp_rsp_if rsp();

   grid_heading_turn_planner_top #(.CORDIC_STEPS(Steps)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req),
      .rsp_ch      (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   ghtp_turn_check #(.CORDIC_STEPS(Steps)) turn_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req),
      .rsp_mon     (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("FAIL grid_heading_turn_planner_top");
      $finish;
   end

   function automatic logic [7:0] random_cell();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(ghtp_tb_pkg::CellCount, 255));
      return 8'($urandom_range(0, ghtp_tb_pkg::CellCount - 1));
   endfunction

   function automatic logic signed [15:0] random_heading();
      int v;
      case ($urandom_range(0, 5))
         0: v = $urandom;
         1: v = $urandom_range(0, 8) - 4;
         2: begin
            case ($urandom_range(0, 3))
               0: v = -32768;
               1: v = 32767;
               2: v = 0;
               default: v = -1;
            endcase
         end
         default: v = $urandom_range(0, 4000) - 2000;
      endcase
      return 16'(v);
   endfunction

   task automatic offer_item(input ghtp_tb_pkg::func_code_type f, input logic [7:0] target,
                             input logic [7:0] current,
                             input logic signed [15:0] hx, input logic signed [15:0] hy);
      req.valid          <= 1'b1;
      req.func           <= f;
      req.target_region  <= target;
      req.current_region <= current;
      req.heading_x      <= hx;
      req.heading_y      <= hy;
      @(posedge clock);
      while (req.ready !== 1'b1) @(posedge clock);
   endtask

   // bursts of back-to-back transactions separated by random idle gaps, which may be empty
   task automatic pace(input int max_gap);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic run_random(input int count, input int max_gap);
      ghtp_tb_pkg::func_code_type f;
      repeat (count) begin
         pace(max_gap);
         f = ($urandom_range(0, 9) < 6) ? ghtp_tb_pkg::FuncPlan : ghtp_tb_pkg::FuncCheck;
         offer_item(f, random_cell(), random_cell(), random_heading(), random_heading());
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_max_accel(input logic [7:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 3'(4 * ghtp_pkg::CsrMaxAccel);
      csr_pwdata  <= {24'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (csr_pready !== 1'b1) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // response side: changing stall patterns plus long holds on request
   initial begin : rsp_sink
      ready_mode_type mode;
      int mode_left, hold_left, tick;
      mode = ReadyAlways;
      mode_left = 0;
      hold_left = 0;
      tick = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left == 0 && hold_requests != holds_served) begin
            holds_served++;
            hold_left = LongHold;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            case (mode)
               ReadyAlways: rsp.ready <= 1'b1;
               ReadyCoin:   rsp.ready <= 1'($urandom_range(0, 1));
               ReadySparse: rsp.ready <= ($urandom_range(0, 3) == 0);
               default:     rsp.ready <= (tick % 7) < 3;
            endcase
         end
      end
   end

   initial begin : stimulus
      reset              <= 1'b1;
      req.valid          <= 1'b0;
      req.func           <= ghtp_tb_pkg::FuncPlan;
      req.target_region  <= 8'd0;
      req.current_region <= 8'd0;
      req.heading_x      <= 16'sd0;
      req.heading_y      <= 16'sd0;
      csr_psel           <= 1'b0;
      csr_penable        <= 1'b0;
      csr_pwrite         <= 1'b0;
      csr_paddr          <= 3'd0;
      csr_pwdata         <= 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset goal and path, invalid target keeps the held goal
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd255, 8'd0, 16'sd100, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncCheck, 8'd9, 8'd5, 16'sd0, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncCheck, 8'd255, 8'd0, -16'sd32768, 16'sd32767);
      // equal cells point the goal straight down the rows
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd5, 8'd5, 16'sd0, 16'sd0);
      drain();

      write_max_accel(8'd255);
      // one entry per ratio, both signs of row and column distance
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd3, 8'd0, 16'sd32767, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd0, 8'd3, -16'sd32768, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd12, 8'd0, 16'sd0, 16'sd32767);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd0, 8'd12, 16'sd0, -16'sd32768);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd7, 8'd0, -16'sd32768, -16'sd32768);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd6, 8'd0, 16'sd32767, 16'sd32767);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd11, 8'd0, 16'sd1, -16'sd1);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd14, 8'd0, -16'sd1, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd9, 8'd0, 16'sd0, 16'sd1);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd13, 8'd0, 16'sd1234, -16'sd4321);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd0, 8'd15, 16'sd0, 16'sd1);
      // invalid current cell, then heading straight opposite the goal
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd3, 8'd16, 16'sd5, 16'sd5);
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd10, 8'd10, 16'sd0, 16'sd255);
      // diagonal path, then cells on and off it and an invalid cell
      pace(3); offer_item(ghtp_tb_pkg::FuncPlan, 8'd15, 8'd0, 16'sd180, 16'sd180);
      pace(3); offer_item(ghtp_tb_pkg::FuncCheck, 8'd0, 8'd5, 16'sd0, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncCheck, 8'd128, 8'd15, 16'sd7, -16'sd7);
      pace(3); offer_item(ghtp_tb_pkg::FuncCheck, 8'd0, 8'd200, 16'sd0, 16'sd0);
      pace(3); offer_item(ghtp_tb_pkg::FuncCheck, 8'd0, 8'd0, 16'sd0, 16'sd0);
      drain();

      run_random(230, 6);
      drain();

      write_max_accel(8'd0);
      run_random(150, 6);
      drain();

      // long response hold while requests keep coming
      write_max_accel(8'd1);
      hold_requests <= hold_requests + 1;
      run_random(100, 0);
      drain();

      write_max_accel(8'($urandom_range(2, 254)));
      run_random(300, 0);
      drain();

      repeat (3) begin
         write_max_accel(8'($urandom_range(0, 255)));
         hold_requests <= hold_requests + 1;
         run_random(250, 8);
         drain();
      end

      repeat (DrainWait) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS grid_heading_turn_planner_top");
      end else begin
         $display("FAIL grid_heading_turn_planner_top");
      end
      $finish;
   end

endmodule

### grid_heading_turn_planner_top.f
src/ghtp_pkg.sv
src/ghtp_req_if.sv
src/ghtp_rsp_if.sv
src/grid_heading_turn_planner_top.sv
tb/sv/ghtp_tb_pkg.sv
tb/sv/ghtp_turn_check.sv
tb/sv/grid_heading_turn_planner_top_test.sv
